[hdl/utce_pkg.sv]
`timescale 1ns / 1ps

package utce_pkg;

  // Width of the signed working year (years since 1900 after month carry)
  localparam int YearW = 12;
  // Width of the signed day count since the epoch
  localparam int DayW  = 21;

  // Time-of-day fields carried alongside the date arithmetic
  typedef struct packed {
    logic [4:0] hr;
    logic [5:0] min;
    logic [5:0] sec;
  } hms_t;

  // Days in the year before the first of the given month (0 = January)
  function automatic logic [8:0] days_before_month(input logic [3:0] mon);
    logic [8:0] d;
    case (mon)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

[hdl/utce_day_count.sv]
`timescale 1ns / 1ps

module utce_day_count
  import utce_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  hms_t                   in_hms,
  input  logic [4:0]             in_mday,
  input  logic signed [7:0]      in_mon,
  input  logic [9:0]             in_yr,
  output logic                   out_valid,
  input  logic                   out_ready,
  output hms_t                   out_hms,
  output logic signed [DayW-1:0] out_days
);

  // Stage 1: month reduction with year carry
  logic                    s1_v_r;
  logic                    s1_ready;
  hms_t                    s1_hms_r;
  logic [4:0]              s1_mday_r;
  logic [3:0]              s1_mon_r;
  logic signed [YearW-1:0] s1_yr_r;
  logic signed [YearW-1:0] s1_leap_r;

  // Stage 2: leap counts and year/month day terms
  logic                    s2_v_r;
  logic                    s2_ready;
  hms_t                    s2_hms_r;
  logic signed [DayW-1:0]  s2_yd_r;
  logic signed [10:0]      s2_md_r;
  logic signed [YearW-1:0] s2_q4_r;
  logic signed [YearW-1:0] s2_q100_r;
  logic [3:0]              s2_q400_r;

  // Stage 3: day sum
  logic                    s3_v_r;
  logic                    s3_ready;
  hms_t                    s3_hms_r;
  logic signed [DayW-1:0]  s3_days_r;

  // Per-stage ready: a stage loads when empty or when its successor loads
  assign s3_ready = !s3_v_r || out_ready;
  assign s2_ready = !s2_v_r || s3_ready;
  assign s1_ready = !s1_v_r || s2_ready;
  assign in_ready = s1_ready;

  // Month magnitude divided by 12 through a reciprocal (exact for 0..128)
  logic [7:0]              mon_abs;
  logic [13:0]             mon_prod;
  logic [3:0]              mon_q;
  logic [3:0]              mon_rem;
  logic                    mon_neg;
  logic                    rem_zero;
  logic signed [YearW-1:0] yr_w;
  logic signed [YearW-1:0] q_w;
  logic [3:0]              s1_mon_nxt;
  logic signed [YearW-1:0] s1_yr_nxt;
  logic signed [YearW-1:0] s1_leap_nxt;

  assign mon_neg  = in_mon[7];
  assign mon_abs  = mon_neg ? (~in_mon + 8'd1) : in_mon;
  assign mon_prod = 14'(mon_abs) * 14'd43;
  assign mon_q    = mon_prod[12:9];
  assign mon_rem  = 4'(mon_abs - 8'(mon_q) * 8'd12);
  assign rem_zero = (mon_rem == 4'd0);
  assign yr_w     = $signed({2'b00, in_yr});
  assign q_w      = $signed({8'b0, mon_q});

  // Fold a negative remainder up into the year before
  always_comb begin
    if (!mon_neg) begin
      s1_mon_nxt = mon_rem;
      s1_yr_nxt  = yr_w + q_w;
    end else if (rem_zero) begin
      s1_mon_nxt = 4'd0;
      s1_yr_nxt  = yr_w - q_w;
    end else begin
      s1_mon_nxt = 4'd12 - mon_rem;
      s1_yr_nxt  = yr_w - q_w - 12'sd1;
    end
    s1_leap_nxt = (s1_mon_nxt > 4'd1) ? s1_yr_nxt + 12'sd1 : s1_yr_nxt;
  end

  // Leap counts, truncating toward zero
  logic signed [YearW-1:0] x4;
  logic signed [YearW-1:0] s2_q4_nxt;
  logic signed [YearW-1:0] x100;
  logic [YearW-1:0]        a100;
  logic [21:0]             p100;
  logic [4:0]              q100_u;
  logic signed [YearW-1:0] q100_s;
  logic signed [YearW-1:0] x400;
  logic [22:0]             p400;
  logic signed [DayW-1:0]  s2_yd_nxt;
  logic signed [10:0]      s2_md_nxt;

  assign x4        = s1_leap_r - 12'sd69;
  assign s2_q4_nxt = x4[YearW-1] ? ((x4 + 12'sd3) >>> 2) : (x4 >>> 2);

  assign x100   = s1_leap_r - 12'sd1;
  assign a100   = x100[YearW-1] ? 12'(-x100) : 12'(x100);
  assign p100   = 22'(a100[10:0]) * 22'd1311;
  assign q100_u = p100[21:17];
  assign q100_s = x100[YearW-1] ? -$signed({7'b0, q100_u}) : $signed({7'b0, q100_u});

  // Year plus 299 never goes negative for any reachable year
  assign x400 = s1_leap_r + 12'sd299;
  assign p400 = 23'(x400[10:0]) * 23'd1311;

  assign s2_yd_nxt = DayW'(s1_yr_r - 12'sd70) * 21'sd365;
  assign s2_md_nxt = $signed({2'b00, days_before_month(s1_mon_r)})
                   + $signed({6'b0, s1_mday_r}) - 11'sd1;

  // Total day count
  logic signed [DayW-1:0] s3_days_nxt;

  assign s3_days_nxt = s2_yd_r + DayW'(s2_md_r) + DayW'(s2_q4_r) - DayW'(s2_q100_r)
                     + $signed({17'b0, s2_q400_r});

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      if (s1_ready) s1_v_r <= in_valid;
      if (s2_ready) s2_v_r <= s1_v_r;
      if (s3_ready) s3_v_r <= s2_v_r;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_hms_r  <= in_hms;
      s1_mday_r <= in_mday;
      s1_mon_r  <= s1_mon_nxt;
      s1_yr_r   <= s1_yr_nxt;
      s1_leap_r <= s1_leap_nxt;
    end
    if (s2_ready) begin
      s2_hms_r  <= s1_hms_r;
      s2_yd_r   <= s2_yd_nxt;
      s2_md_r   <= s2_md_nxt;
      s2_q4_r   <= s2_q4_nxt;
      s2_q100_r <= q100_s;
      s2_q400_r <= p400[22:19];
    end
    if (s3_ready) begin
      s3_hms_r  <= s2_hms_r;
      s3_days_r <= s3_days_nxt;
    end
  end

  assign out_valid = s3_v_r;
  assign out_hms   = s3_hms_r;
  assign out_days  = s3_days_r;

endmodule

[hdl/utc_calendar_to_epoch_seconds_top.sv]
`timescale 1ns / 1ps

// Converts a broken-down UTC time (second, minute, hour, day of month, signed
// month index, years since 1900) into seconds since 1970-01-01 00:00:00 on the
// proleptic Gregorian calendar without leap seconds. The month index may lie
// outside 0..11 and carries into the year. A time before the epoch returns
// zero seconds with out_tuser set. The block is a six-stage pipeline: three
// stages for the day count (month carry, leap counts, day sum) and three for
// the hour, minute and second scaling. It takes one transaction per cycle
// while in_tready is high, which drops only when every stage is full and
// out_tready is low; each stage holds its data while the stage after it is
// full and stalled, so empty stages keep filling while out_tready is low.

module utc_calendar_to_epoch_seconds_top
  import utce_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // second[5:0], minute[11:6], hour[16:12], day_of_month[21:17],
  // month_index[29:22], years_since_1900[39:30]
  input  logic [39:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // epoch_seconds[34:0], zero fill[39:35]
  output logic [39:0] out_tdata,
  // is_bad[0]
  output logic        out_tuser
);

  hms_t                   in_hms;
  logic                   dc_valid;
  logic                   dc_ready;
  hms_t                   dc_hms;
  logic signed [DayW-1:0] dc_days;

  assign in_hms.sec = in_tdata[5:0];
  assign in_hms.min = in_tdata[11:6];
  assign in_hms.hr  = in_tdata[16:12];

  utce_day_count u_day_count (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_hms    (in_hms),
    .in_mday   (in_tdata[21:17]),
    .in_mon    ($signed(in_tdata[29:22])),
    .in_yr     (in_tdata[39:30]),
    .out_valid (dc_valid),
    .out_ready (dc_ready),
    .out_hms   (dc_hms),
    .out_days  (dc_days)
  );

  // Stage 4: hours
  logic               s4_v_r;
  logic               s4_ready;
  logic [5:0]         s4_min_r;
  logic [5:0]         s4_sec_r;
  logic signed [25:0] s4_hrs_r;
  // Stage 5: minutes
  logic               s5_v_r;
  logic               s5_ready;
  logic [5:0]         s5_sec_r;
  logic signed [31:0] s5_mins_r;
  // Stage 6: seconds and output register
  logic               s6_v_r;
  logic               s6_ready;
  logic [34:0]        s6_secs_r;
  logic               s6_bad_r;

  assign s6_ready = !s6_v_r || out_tready;
  assign s5_ready = !s5_v_r || s6_ready;
  assign s4_ready = !s4_v_r || s5_ready;
  assign dc_ready = s4_ready;

  logic signed [25:0] s4_hrs_nxt;
  logic signed [31:0] s5_mins_nxt;
  logic signed [37:0] total;

  assign s4_hrs_nxt  = 26'(dc_days) * 26'sd24 + $signed({21'b0, dc_hms.hr});
  assign s5_mins_nxt = 32'(s4_hrs_r) * 32'sd60 + $signed({26'b0, s4_min_r});
  assign total       = 38'(s5_mins_r) * 38'sd60 + $signed({32'b0, s5_sec_r});

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
      s6_v_r <= 1'b0;
    end else begin
      if (s4_ready) s4_v_r <= dc_valid;
      if (s5_ready) s5_v_r <= s4_v_r;
      if (s6_ready) s6_v_r <= s5_v_r;
    end
  end

  // Advance payload; clamp a time before the epoch to zero
  always_ff @(posedge clk) begin
    if (s4_ready) begin
      s4_min_r <= dc_hms.min;
      s4_sec_r <= dc_hms.sec;
      s4_hrs_r <= s4_hrs_nxt;
    end
    if (s5_ready) begin
      s5_sec_r  <= s4_sec_r;
      s5_mins_r <= s5_mins_nxt;
    end
    if (s6_ready) begin
      s6_bad_r  <= total[37];
      s6_secs_r <= total[37] ? 35'd0 : total[34:0];
    end
  end

  assign out_tvalid = s6_v_r;
  assign out_tdata  = {5'b0, s6_secs_r};
  assign out_tuser  = s6_bad_r;

endmodule
